// ===== rtl/mi3_pkg.sv =====
// shared types and constants for the 3x3 matrix inverse
`timescale 1ns / 1ps
`default_nettype none

package mi3_pkg;

    localparam int unsigned FRAC_BITS_DEF = 24;
    localparam int unsigned WORD_W        = 32;
    localparam int unsigned N_ENT         = 9;
    localparam int unsigned N_ROW         = 3;
    localparam int unsigned PROD_W        = 64;
    localparam int unsigned ADJ_W         = 64;
    localparam int unsigned TERM_W        = 97;
    localparam int unsigned DET_W         = 98;
    localparam int unsigned MAG_W         = 97;
    localparam int unsigned QUO_W         = 33;
    localparam int unsigned QUEUE_DEPTH   = 2;
    localparam logic [WORD_W-1:0] THR_RESET = 32'd168;

    // saturation limits of the rounded quotient magnitude
    localparam logic [QUO_W-1:0] LIM_POS = 33'h0_7FFF_FFFF;
    localparam logic [QUO_W-1:0] LIM_NEG = 33'h0_8000_0000;

    // adj[k] = e[a]*e[b] - e[c]*e[d], entries indexed 3*row + col
    localparam int unsigned COF_IDX [N_ENT][4] = '{
        '{4, 8, 5, 7},
        '{2, 7, 1, 8},
        '{1, 5, 2, 4},
        '{5, 6, 3, 8},
        '{0, 8, 2, 6},
        '{2, 3, 0, 5},
        '{3, 7, 4, 6},
        '{1, 6, 0, 7},
        '{0, 4, 1, 3}
    };

    typedef struct packed {
        logic signed [WORD_W-1:0] e00;
        logic signed [WORD_W-1:0] e01;
        logic signed [WORD_W-1:0] e02;
        logic signed [WORD_W-1:0] e10;
        logic signed [WORD_W-1:0] e11;
        logic signed [WORD_W-1:0] e12;
        logic signed [WORD_W-1:0] e20;
        logic signed [WORD_W-1:0] e21;
        logic signed [WORD_W-1:0] e22;
    } t_mat_in;

    typedef struct packed {
        logic signed [WORD_W-1:0] r00;
        logic signed [WORD_W-1:0] r01;
        logic signed [WORD_W-1:0] r02;
        logic signed [WORD_W-1:0] r10;
        logic signed [WORD_W-1:0] r11;
        logic signed [WORD_W-1:0] r12;
        logic signed [WORD_W-1:0] r20;
        logic signed [WORD_W-1:0] r21;
        logic signed [WORD_W-1:0] r22;
        logic                     singular;
    } t_mat_out;

    // one classified matrix waiting for the divider
    typedef struct packed {
        logic [N_ENT-1:0][ADJ_W-1:0] adj;
        logic [MAG_W-1:0]            det_mag;
        logic                        det_neg;
        logic                        singular;
    } t_job;

endpackage

`default_nettype wire

// ===== rtl/mi3_stream_if.sv =====
// valid/ready stream interface with a typed payload
`timescale 1ns / 1ps
`default_nettype none

interface mi3_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/mi3_front.sv =====
// front end: cofactors, determinant and singular classification
`timescale 1ns / 1ps
`default_nettype none

module mi3_front #(
    parameter int unsigned FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    mi3_stream_if.sink                       i_mat,
    input  wire logic [mi3_pkg::WORD_W-1:0]  i_thr,
    output mi3_pkg::t_job                    o_job,
    output logic                             o_job_vld,
    input  wire logic                        i_job_rdy
);

    localparam int unsigned SH = 2 * FRAC_BITS;

    logic en;
    logic signed [mi3_pkg::WORD_W-1:0] e [mi3_pkg::N_ENT];

    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;

    logic signed [mi3_pkg::PROD_W-1:0] r_pa   [mi3_pkg::N_ENT];
    logic signed [mi3_pkg::PROD_W-1:0] r_pb   [mi3_pkg::N_ENT];
    logic signed [mi3_pkg::WORD_W-1:0] r_e1   [mi3_pkg::N_ROW];
    logic signed [mi3_pkg::WORD_W-1:0] r_e2   [mi3_pkg::N_ROW];
    logic signed [mi3_pkg::ADJ_W-1:0]  r_adj2 [mi3_pkg::N_ENT];
    logic signed [mi3_pkg::ADJ_W-1:0]  r_adj3 [mi3_pkg::N_ENT];
    logic signed [mi3_pkg::ADJ_W-1:0]  r_adj4 [mi3_pkg::N_ENT];
    logic signed [mi3_pkg::ADJ_W-1:0]  r_adj5 [mi3_pkg::N_ENT];
    logic signed [mi3_pkg::PROD_W-1:0] r_ph   [mi3_pkg::N_ROW];
    logic signed [mi3_pkg::PROD_W:0]   r_pl   [mi3_pkg::N_ROW];
    logic signed [mi3_pkg::TERM_W-1:0] r_term [mi3_pkg::N_ROW];
    logic signed [mi3_pkg::DET_W-1:0]  r_det;
    mi3_pkg::t_job                     r_job;

    logic                             det_neg;
    logic [mi3_pkg::DET_W-1:0]        det_abs;
    logic [mi3_pkg::MAG_W-1:0]        det_mag;
    logic [mi3_pkg::MAG_W-1:0]        thr_sh;

    assign e[0] = i_mat.data.e00;
    assign e[1] = i_mat.data.e01;
    assign e[2] = i_mat.data.e02;
    assign e[3] = i_mat.data.e10;
    assign e[4] = i_mat.data.e11;
    assign e[5] = i_mat.data.e12;
    assign e[6] = i_mat.data.e20;
    assign e[7] = i_mat.data.e21;
    assign e[8] = i_mat.data.e22;

    // whole front advances unless the last stage is blocked by a full queue
    assign en          = !r_v6 || i_job_rdy;
    assign i_mat.ready = en;
    assign o_job_vld   = r_v6;
    assign o_job       = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_mat.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_comb begin
        det_neg = r_det[mi3_pkg::DET_W-1];
        det_abs = det_neg ? mi3_pkg::DET_W'(-r_det) : mi3_pkg::DET_W'(r_det);
        det_mag = det_abs[mi3_pkg::MAG_W-1:0];
        thr_sh  = mi3_pkg::MAG_W'(i_thr) << SH;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < mi3_pkg::N_ENT; k++) begin
                r_pa[k]   <= e[mi3_pkg::COF_IDX[k][0]] * e[mi3_pkg::COF_IDX[k][1]];
                r_pb[k]   <= e[mi3_pkg::COF_IDX[k][2]] * e[mi3_pkg::COF_IDX[k][3]];
                r_adj2[k] <= r_pa[k] - r_pb[k];
                r_adj3[k] <= r_adj2[k];
                r_adj4[k] <= r_adj3[k];
                r_adj5[k] <= r_adj4[k];
                r_job.adj[k] <= r_adj5[k];
            end
            for (int i = 0; i < mi3_pkg::N_ROW; i++) begin
                r_e1[i] <= e[i];
                r_e2[i] <= r_e1[i];
                // split the 64-bit cofactor into two 32-bit halves
                r_ph[i] <= r_e2[i] * $signed(r_adj2[3*i][63:32]);
                r_pl[i] <= r_e2[i] * $signed({1'b0, r_adj2[3*i][31:0]});
                r_term[i] <= $signed({r_ph[i][63], r_ph[i], 32'd0})
                           + $signed({{32{r_pl[i][64]}}, r_pl[i]});
            end
            r_det <= mi3_pkg::DET_W'(r_term[0]) + mi3_pkg::DET_W'(r_term[1])
                   + mi3_pkg::DET_W'(r_term[2]);
            r_job.det_mag  <= det_mag;
            r_job.det_neg  <= det_neg;
            r_job.singular <= (det_mag < thr_sh) || (det_mag == '0);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mi3_fifo.sv =====
// short queue between the front end and the divider
`timescale 1ns / 1ps
`default_nettype none

module mi3_fifo #(
    parameter int unsigned DEPTH = mi3_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  mi3_pkg::t_job      i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output mi3_pkg::t_job      o_data,
    output logic               o_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    mi3_pkg::t_job  r_mem [DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [PW:0]    r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mi3_back.sv =====
// back end: nine restoring dividers in lockstep, rounding and saturation
`timescale 1ns / 1ps
`default_nettype none

module mi3_back #(
    parameter int unsigned FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  mi3_pkg::t_job  i_job,
    input  wire logic      i_job_vld,
    output logic           o_job_pop,
    mi3_stream_if.source   o_inv
);

    localparam int unsigned QW    = mi3_pkg::QUO_W;
    localparam int unsigned NE    = mi3_pkg::N_ENT;
    localparam int unsigned MW    = mi3_pkg::MAG_W;
    localparam int unsigned NUM_W = mi3_pkg::ADJ_W + 2*FRAC_BITS + 1;
    localparam int unsigned HI_W  = NUM_W - QW;
    localparam int unsigned LAST  = QW + 1;

    logic en;
    logic [LAST:0] r_v;

    logic [MW-1:0]   r_rem  [QW+1][NE];
    logic [QW-1:0]   r_q    [QW+1][NE];
    logic [QW-1:0]   r_lo   [QW+1][NE];
    logic [NE-1:0]   r_neg  [QW+1];
    logic [NE-1:0]   r_ovf  [QW+1];
    logic [MW-1:0]   r_dmag [QW+1];
    logic            r_sing [QW+1];
    mi3_pkg::t_mat_out r_out;

    logic [mi3_pkg::ADJ_W-1:0] amag [NE];
    logic [NUM_W-1:0]          num  [NE];
    logic [HI_W-1:0]           hi   [NE];
    logic [NE-1:0]             ovf0;
    logic [NE-1:0]             neg0;
    logic [MW-1:0]             trial [1:QW][NE];
    logic [NE-1:0]             ge    [1:QW];
    logic [QW:0]               rnd  [NE];
    logic [QW-1:0]             rq   [NE];
    logic [QW-1:0]             lim  [NE];
    logic [QW-1:0]             mg   [NE];
    logic [QW-1:0]             mgn  [NE];
    logic [mi3_pkg::WORD_W-1:0] res [NE];

    assign en          = !r_v[LAST] || o_inv.ready;
    assign o_job_pop   = en && i_job_vld;
    assign o_inv.valid = r_v[LAST];
    assign o_inv.data  = r_out;

    // numerator is |adj| * 2^(2F+1); its top part must stay below the divisor
    always_comb begin
        for (int j = 0; j < NE; j++) begin
            neg0[j] = i_job.adj[j][mi3_pkg::ADJ_W-1] ^ i_job.det_neg;
            amag[j] = i_job.adj[j][mi3_pkg::ADJ_W-1] ? -i_job.adj[j] : i_job.adj[j];
            num[j]  = NUM_W'(amag[j]) << (2*FRAC_BITS + 1);
            hi[j]   = num[j][NUM_W-1:QW];
            ovf0[j] = (MW'(hi[j]) >= i_job.det_mag);
        end
    end

    always_comb begin
        for (int k = 1; k <= QW; k++) begin
            for (int j = 0; j < NE; j++) begin
                trial[k][j] = {r_rem[k-1][j][MW-2:0], r_lo[k-1][j][QW-1]};
                ge[k][j]    = (trial[k][j] >= r_dmag[k-1]);
            end
        end
    end

    // round half away from zero on the magnitude, then clamp
    always_comb begin
        for (int j = 0; j < NE; j++) begin
            rnd[j] = (QW+1)'(r_q[QW][j]) + 1'b1;
            rq[j]  = rnd[j][QW:1];
            lim[j] = r_neg[QW][j] ? mi3_pkg::LIM_NEG : mi3_pkg::LIM_POS;
            mg[j]  = (r_ovf[QW][j] || (rq[j] > lim[j])) ? lim[j] : rq[j];
            mgn[j] = ~mg[j] + 1'b1;
            if (r_sing[QW]) begin
                res[j] = '0;
            end else if (r_neg[QW][j]) begin
                res[j] = mgn[j][mi3_pkg::WORD_W-1:0];
            end else begin
                res[j] = mg[j][mi3_pkg::WORD_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[LAST-1:0], i_job_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j < NE; j++) begin
                r_rem[0][j] <= ovf0[j] ? '0 : MW'(hi[j]);
                r_q[0][j]   <= '0;
                r_lo[0][j]  <= num[j][QW-1:0];
            end
            r_neg[0]  <= neg0;
            r_ovf[0]  <= ovf0;
            r_dmag[0] <= i_job.det_mag;
            r_sing[0] <= i_job.singular;
            for (int k = 1; k <= QW; k++) begin
                for (int j = 0; j < NE; j++) begin
                    r_rem[k][j] <= ge[k][j] ? trial[k][j] - r_dmag[k-1] : trial[k][j];
                    r_q[k][j]   <= {r_q[k-1][j][QW-2:0], ge[k][j]};
                    r_lo[k][j]  <= {r_lo[k-1][j][QW-2:0], 1'b0};
                end
                r_neg[k]  <= r_neg[k-1];
                r_ovf[k]  <= r_ovf[k-1];
                r_dmag[k] <= r_dmag[k-1];
                r_sing[k] <= r_sing[k-1];
            end
            r_out.r00      <= res[0];
            r_out.r01      <= res[1];
            r_out.r02      <= res[2];
            r_out.r10      <= res[3];
            r_out.r11      <= res[4];
            r_out.r12      <= res[5];
            r_out.r20      <= res[6];
            r_out.r21      <= res[7];
            r_out.r22      <= res[8];
            r_out.singular <= r_sing[QW];
        end
    end

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_inv.valid && o_inv.data.singular) |->
            (o_inv.data.r00 == '0) && (o_inv.data.r11 == '0) && (o_inv.data.r22 == '0)
            && (o_inv.data.r01 == '0) && (o_inv.data.r12 == '0) && (o_inv.data.r20 == '0))
        else $error("singular result with nonzero entries");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_v[0]) |=> r_v[1])
        else $error("divider stage lost an item");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_v))
        else $error("divider moved while stalled");

endmodule

`default_nettype wire

// ===== rtl/matrix3x3_inverse.sv =====
// 3x3 fixed-point matrix inverse, top level
// pipeline: 6 front stages, the queue, 33 divider steps plus entry and output stages
// throughput: one matrix per cycle unless a stall holds the flow;
//   the 33-step restoring divider is fully pipelined
// a 2-entry queue parts the front end and the divider so each can stall alone
// reset (synchronous, active low) empties the pipeline and queue, threshold back to 168
`timescale 1ns / 1ps
`default_nettype none

module matrix3x3_inverse #(
    parameter int unsigned FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    mi3_stream_if.sink                       i_mat,
    mi3_stream_if.source                     o_inv,
    input  wire logic                        i_cfg_we,
    input  wire logic [mi3_pkg::WORD_W-1:0]  i_cfg_wdata
);

    logic [mi3_pkg::WORD_W-1:0] r_thr;

    mi3_pkg::t_job front_job;
    logic          front_vld;
    logic          q_full;
    mi3_pkg::t_job q_job;
    logic          q_empty;
    logic          q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= mi3_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    mi3_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mat     (i_mat),
        .i_thr     (r_thr),
        .o_job     (front_job),
        .o_job_vld (front_vld),
        .i_job_rdy (!q_full)
    );

    mi3_fifo #(
        .DEPTH (mi3_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_vld && !q_full),
        .i_data  (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_job),
        .o_empty (q_empty)
    );

    mi3_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (q_job),
        .i_job_vld (!q_empty),
        .o_job_pop (q_pop),
        .o_inv     (o_inv)
    );

endmodule

`default_nettype wire

// ===== tb/mi3_inverse_checker.sv =====
// checker for the 3x3 matrix inverse: predicts each inverse and compares transfers
`timescale 1ns / 1ps
`default_nettype none

module mi3_inverse_checker
    import mi3_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_mat_valid,
    input  wire logic              i_mat_ready,
    input  wire t_mat_in           i_mat_data,
    input  wire logic              i_inv_valid,
    input  wire logic              i_inv_ready,
    input  wire t_mat_out          i_inv_data,
    input  wire logic              i_cfg_we,
    input  wire logic [WORD_W-1:0] i_cfg_wdata,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked,
    output int                     o_singular_seen
);

    localparam int unsigned SCALE = 2 * FRAC_BITS_DEF;

    logic [WORD_W-1:0] threshold;
    t_mat_out          inverse_queue[$];

    // exact adjugate over determinant, rounded half away from zero, saturated
    function automatic t_mat_out inverse_of(t_mat_in m, logic [WORD_W-1:0] thr);
        logic signed [129:0] ent[N_ENT];
        logic signed [129:0] cof[N_ENT];
        logic signed [129:0] det;
        logic [129:0]        det_mag;
        logic [129:0]        num;
        logic [129:0]        q;
        logic [129:0]        rem;
        logic [129:0]        lim;
        logic [129:0]        sat;
        logic                neg;
        t_mat_out            o;
        for (int k = 0; k < N_ENT; k++) begin
            ent[k] = $signed(m[WORD_W*(N_ENT-1-k) +: WORD_W]);
        end
        for (int k = 0; k < N_ENT; k++) begin
            cof[k] = ent[COF_IDX[k][0]] * ent[COF_IDX[k][1]]
                   - ent[COF_IDX[k][2]] * ent[COF_IDX[k][3]];
        end
        det     = ent[0] * cof[0] + ent[1] * cof[3] + ent[2] * cof[6];
        det_mag = det[129] ? -det : det;
        lim     = {98'd0, thr} << SCALE;
        o       = '0;
        if (det_mag < lim || det == 0) begin
            o.singular = 1'b1;
            return o;
        end
        for (int k = 0; k < N_ENT; k++) begin
            neg = cof[k][129] ^ det[129];
            num = (cof[k][129] ? -cof[k] : cof[k]);
            num = num << SCALE;
            q   = num / det_mag;
            rem = num % det_mag;
            if ((rem << 1) >= det_mag) q = q + 1;
            sat = neg ? 130'h8000_0000 : 130'h7FFF_FFFF;
            if (q > sat) q = sat;
            o[1 + WORD_W*(N_ENT-1-k) +: WORD_W] = neg ? -q[WORD_W-1:0] : q[WORD_W-1:0];
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                   logic [WORD_W-1:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count    = 0;
        o_checked       = 0;
        o_singular_seen = 0;
        threshold       = THR_RESET;
    end

    assign o_pending = inverse_queue.size();

    always @(posedge i_clk) begin
        t_mat_out want;
        string    nm;
        if (!i_rst_n) begin
            threshold = THR_RESET;
            inverse_queue.delete();
        end else begin
            if (i_mat_valid && i_mat_ready) begin
                inverse_queue.push_back(inverse_of(i_mat_data, threshold));
            end
            if (i_inv_valid && i_inv_ready) begin
                if (inverse_queue.size() == 0) begin
                    report_mismatch("unexpected transfer", 32'd0, 32'd0);
                end else begin
                    want = inverse_queue.pop_front();
                    o_checked++;
                    if (want.singular) o_singular_seen++;
                    if (i_inv_data.singular !== want.singular) begin
                        report_mismatch("singular", 32'(i_inv_data.singular),
                                        32'(want.singular));
                    end
                    for (int k = 0; k < N_ENT; k++) begin
                        if (i_inv_data[1 + WORD_W*(N_ENT-1-k) +: WORD_W] !==
                            want[1 + WORD_W*(N_ENT-1-k) +: WORD_W]) begin
                            nm = $sformatf("r%0d%0d", k / N_ROW, k % N_ROW);
                            report_mismatch(nm,
                                i_inv_data[1 + WORD_W*(N_ENT-1-k) +: WORD_W],
                                want[1 + WORD_W*(N_ENT-1-k) +: WORD_W]);
                        end
                    end
                end
            end
            // threshold takes effect for transfers after this edge
            if (i_cfg_we) threshold = i_cfg_wdata;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_matrix3x3_inverse.sv =====
// testbench top for the 3x3 matrix inverse: stimulus, flow control and verdict
`timescale 1ns / 1ps
`default_nettype none

module tb_matrix3x3_inverse;
    import mi3_pkg::*;

    localparam int IDLE_LIMIT  = 3000;
    localparam int DRAIN_WAIT  = 60;
    localparam int HOLD_CYCLES = 300;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [WORD_W-1:0] i_cfg_wdata;
    logic              hold_off_req;
    int                fail_count;
    int                pending;
    int                checked;
    int                singular_seen;
    int                idle_cycles;
    int                sent;

    mi3_stream_if #(.t_payload(t_mat_in))  mat_if ();
    mi3_stream_if #(.t_payload(t_mat_out)) inv_if ();

    matrix3x3_inverse dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mat       (mat_if),
        .o_inv       (inv_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    mi3_inverse_checker checker_u (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_mat_valid     (mat_if.valid),
        .i_mat_ready     (mat_if.ready),
        .i_mat_data      (mat_if.data),
        .i_inv_valid     (inv_if.valid),
        .i_inv_ready     (inv_if.ready),
        .i_inv_data      (inv_if.data),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_singular_seen (singular_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_mat_in pack_mat(logic [WORD_W-1:0] w[N_ENT]);
        t_mat_in m;
        for (int k = 0; k < N_ENT; k++) m[WORD_W*(N_ENT-1-k) +: WORD_W] = w[k];
        return m;
    endfunction

    task automatic send_matrix(t_mat_in m);
        int gap;
        mat_if.valid = 1'b1;
        mat_if.data  = m;
        do @(posedge i_clk); while (!mat_if.ready);
        @(negedge i_clk);
        sent++;
        gap = gap_len();
        if (gap != 0) begin
            mat_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_entries(logic [WORD_W-1:0] w[N_ENT]);
        send_matrix(pack_mat(w));
    endtask

    task automatic set_threshold(logic [WORD_W-1:0] thr);
        mat_if.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = thr;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'h0000_0001;
            4: return 32'hFFFF_FFFF;
            default: return 32'h0100_0000;
        endcase
    endfunction

    task automatic send_random();
        logic [WORD_W-1:0] w[N_ENT];
        int                kind;
        kind = $urandom_range(0, 99);
        for (int k = 0; k < N_ENT; k++) begin
            if (kind < 50) begin
                // mostly strong diagonal (a negative one can be tiny), small off-diagonal
                if (k % 4 == 0)
                    w[k] = ($urandom_range(0, 1) ? 1 : -1) *
                           ($urandom_range(1, 4) << 24) + $urandom_range(0, 32'hFF_FFFF);
                else
                    w[k] = $signed($urandom_range(0, 32'h1FF_FFFF)) - 32'sh100_0000;
            end else if (kind < 65) begin
                w[k] = $urandom();
            end else if (kind < 80) begin
                w[k] = $signed($urandom_range(0, 1023)) - 512;
            end else if (kind < 90) begin
                w[k] = $signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
            end else begin
                w[k] = pick_extreme();
            end
        end
        // dependent third row
        if (kind >= 80 && kind < 90) begin
            for (int c = 0; c < N_ROW; c++) w[6 + c] = w[c] + w[3 + c];
        end
        send_entries(w);
    endtask

    // receiver flow control, with one long hold-off on request
    initial begin
        inv_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                inv_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
            end
            inv_if.ready = (gap_len() == 0) || ($urandom_range(0, 2) == 0);
        end
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((mat_if.valid && mat_if.ready) || (inv_if.valid && inv_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("matrix3x3_inverse verification failed");
            $finish;
        end
    end

    initial begin
        logic [WORD_W-1:0] w[N_ENT];
        logic [WORD_W-1:0] thr_set[4];
        idle_cycles  = 0;
        sent         = 0;
        hold_off_req = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        mat_if.valid = 1'b0;
        mat_if.data  = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // identity, diagonal, zero, full-scale and sign-extreme matrices
        w = '{32'h0100_0000, 0, 0, 0, 32'h0100_0000, 0, 0, 0, 32'h0100_0000};
        send_entries(w);
        w = '{32'h0200_0000, 0, 0, 0, 32'hFF00_0000, 0, 0, 0, 32'h0040_0000};
        send_entries(w);
        w = '{default: 32'h0};
        send_entries(w);
        w = '{default: 32'h7FFF_FFFF};
        send_entries(w);
        w = '{32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h8000_0000};
        send_entries(w);
        w = '{32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF};
        send_entries(w);
        // tiny diagonal: determinant falls below the reset threshold, so the result is singular
        w = '{32'h1, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 32'h0001_0000};
        send_entries(w);
        // determinant below the reset threshold: both matrices are singular
        w = '{32'h0000_0100, 0, 0, 0, 32'h0000_0100, 0, 0, 0, 32'h00A8_0000};
        send_entries(w);
        w = '{32'h0000_0100, 0, 0, 0, 32'h0000_0100, 0, 0, 0, 32'h00A7_FFFF};
        send_entries(w);
        // 3 and -3 on the diagonal: quotient is not exact and is rounded to nearest
        w = '{32'h0300_0000, 0, 0, 0, 32'h0100_0000, 0, 0, 0, 32'h0100_0000};
        send_entries(w);
        w = '{32'hFD00_0000, 0, 0, 0, 32'h0100_0000, 0, 0, 0, 32'h0100_0000};
        send_entries(w);
        w = '{32'h0100_0000, 32'h0200_0000, 32'h0300_0000, 32'h0400_0000, 32'h0500_0000,
              32'h0600_0000, 32'h0700_0000, 32'h0800_0000, 32'h0A00_0000};
        send_entries(w);
        w = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF};
        send_entries(w);

        // zero threshold: only an exact zero determinant is singular
        set_threshold(32'h0);
        w = '{default: 32'h0};
        send_entries(w);
        w = '{32'h1, 0, 0, 0, 32'h1, 0, 0, 0, 32'h1};
        send_entries(w);
        // largest threshold: even a unit-scale matrix counts as singular
        set_threshold(32'hFFFF_FFFF);
        w = '{32'h0100_0000, 0, 0, 0, 32'h0100_0000, 0, 0, 0, 32'h0100_0000};
        send_entries(w);
        w = '{32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF};
        send_entries(w);

        thr_set = '{THR_RESET, 32'h0, $urandom(), 32'h1};
        for (int ph = 0; ph < 4; ph++) begin
            set_threshold(thr_set[ph]);
            if (ph == 0) hold_off_req = 1'b1;
            for (int n = 0; n < 235; n++) send_random();
        end
        mat_if.valid = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        $display("sent %0d matrices over six threshold settings, %0d results checked",
                 sent, checked);
        $display("%0d singular, %0d inverted, receiver held off once for %0d cycles",
                 singular_seen, checked - singular_seen, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("matrix3x3_inverse verification clean");
        else
            $display("matrix3x3_inverse verification failed");
        $finish;
    end

endmodule

`default_nettype wire
